[hw/rtl/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg
// shared types and constants of the status blink classifier
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int CFG_BITS       = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_BITS-1:0] BATTERY_TIMEOUT_RST = 16'd3000;
	localparam logic [CFG_BITS-1:0] CHARGING_PERIOD_RST = 16'd2000;
	localparam logic [CFG_BITS-1:0] ERROR_PERIOD_RST    = 16'd400;
	localparam logic [CFG_BITS-1:0] CHARGER_TIMEOUT_RST = 16'd500;

	typedef enum logic [1:0] {
		CFG_BATTERY_TIMEOUT = 2'd0,
		CFG_CHARGING_PERIOD = 2'd1,
		CFG_ERROR_PERIOD    = 2'd2,
		CFG_CHARGER_TIMEOUT = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] battery_timeout;
		logic [CFG_BITS-1:0] charging_period;
		logic [CFG_BITS-1:0] error_period;
		logic [CFG_BITS-1:0] charger_timeout;
	} cfg_t;

	typedef struct packed {
		logic battery_charged;
		logic battery_charging;
		logic battery_error;
		logic supply_connected;
		logic charger_fault;
	} result_t;

endpackage

[hw/rtl/sbc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sbc_cfg_regs
// configuration registers: timeouts and nominal blink periods
// ----------------------------------------------------------------------------
module sbc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [sbc_pkg::CFG_BITS-1:0]   cfg_data,
	output sbc_pkg::cfg_t                  cfg
);
	import sbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_timeout <= BATTERY_TIMEOUT_RST;
			cfg_q.charging_period <= CHARGING_PERIOD_RST;
			cfg_q.error_period    <= ERROR_PERIOD_RST;
			cfg_q.charger_timeout <= CHARGER_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_BATTERY_TIMEOUT: cfg_q.battery_timeout <= cfg_data;
				CFG_CHARGING_PERIOD: cfg_q.charging_period <= cfg_data;
				CFG_ERROR_PERIOD:    cfg_q.error_period    <= cfg_data;
				CFG_CHARGER_TIMEOUT: cfg_q.charger_timeout <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/sbc_classify.sv]
// ----------------------------------------------------------------------------
// sbc_classify
// edge detect, saturating tick counters and line classification
// ----------------------------------------------------------------------------
module sbc_classify #(
	parameter int COUNT_BITS = sbc_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             battery_level,
	input  logic             charger_level,
	input  sbc_pkg::cfg_t    cfg,
	output sbc_pkg::result_t res
);
	import sbc_pkg::*;

	localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic                  b_prev_q, c_prev_q;
	logic [COUNT_BITS-1:0] b_since_q, b_period_q, c_since_q;

	logic                  b_edge, c_edge;
	logic [COUNT_BITS-1:0] b_inc, c_inc;
	logic [COUNT_BITS-1:0] b_since_n, b_period_n, c_since_n;
	logic                  b_blink, c_blink;
	logic [CMP_BITS-1:0]   period_x, charging_x, error_x, dc, de;

	assign b_edge = battery_level && !b_prev_q;
	assign c_edge = charger_level && !c_prev_q;

	assign b_inc = (b_since_q == COUNT_MAX) ? b_since_q : b_since_q + 1'b1;
	assign c_inc = (c_since_q == COUNT_MAX) ? c_since_q : c_since_q + 1'b1;

	assign b_since_n  = b_edge ? '0 : b_inc;
	assign b_period_n = b_edge ? b_inc : b_period_q;
	assign c_since_n  = c_edge ? '0 : c_inc;

	assign b_blink = CMP_BITS'(b_since_n) < CMP_BITS'(cfg.battery_timeout);
	assign c_blink = CMP_BITS'(c_since_n) < CMP_BITS'(cfg.charger_timeout);

	assign period_x   = CMP_BITS'(b_period_n);
	assign charging_x = CMP_BITS'(cfg.charging_period);
	assign error_x    = CMP_BITS'(cfg.error_period);
	assign dc = (charging_x >= period_x) ? charging_x - period_x : period_x - charging_x;
	assign de = (error_x >= period_x) ? error_x - period_x : period_x - error_x;

	always_comb begin
		res.battery_charged  = !b_blink && battery_level;
		res.battery_charging = b_blink && (dc < de);
		res.battery_error    = b_blink && (de < dc);
		res.supply_connected = !c_blink && charger_level;
		res.charger_fault    = c_blink;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_prev_q   <= 1'b0;
			c_prev_q   <= 1'b0;
			b_since_q  <= '0;
			b_period_q <= '0;
			c_since_q  <= '0;
		end else if (step) begin
			b_prev_q   <= battery_level;
			c_prev_q   <= charger_level;
			b_since_q  <= b_since_n;
			b_period_q <= b_period_n;
			c_since_q  <= c_since_n;
		end
	end

endmodule

[hw/rtl/status_blink_classifier_unit.sv]
// ----------------------------------------------------------------------------
// status_blink_classifier_unit
// classifies battery and charger status lines from one tick per request
// ----------------------------------------------------------------------------
// channel   signals                          width  direction
// in        in_valid/in_ready, *_level       1+1    request in
// out       out_valid/out_ready, 5 flags     5      result out
// cfg       cfg_we, cfg_index, cfg_data      2/16   write only
//
// one request per cycle sustained while the output is not stalled; a request
// passes the input register, then the classify logic into the result register
// reset clears the counters, previous levels and both stage valids; the
// configuration registers return to their nominal values
// a stalled output holds the result; one more request waits in the input stage
// ----------------------------------------------------------------------------
module status_blink_classifier_unit #(
	parameter int COUNT_BITS = sbc_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         battery_level,
	input  logic                         charger_level,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         battery_charged,
	output logic                         battery_charging,
	output logic                         battery_error,
	output logic                         supply_connected,
	output logic                         charger_fault,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [sbc_pkg::CFG_BITS-1:0] cfg_data
);
	import sbc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_s2;

	logic valid_s1, bl_s1, cl_s1;
	logic valid_s2;
	logic s2_load, step;

	sbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbc_classify #(.COUNT_BITS(COUNT_BITS)) u_classify (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.battery_level (bl_s1),
		.charger_level (cl_s1),
		.cfg           (cfg),
		.res           (res)
	);

	assign s2_load  = !valid_s2 || out_ready;
	assign step     = valid_s1 && s2_load;
	assign in_ready = !valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (s2_load)  valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bl_s1 <= battery_level;
			cl_s1 <= charger_level;
		end
		if (step) res_s2 <= res;
	end

	assign out_valid        = valid_s2;
	assign battery_charged  = res_s2.battery_charged;
	assign battery_charging = res_s2.battery_charging;
	assign battery_error    = res_s2.battery_error;
	assign supply_connected = res_s2.supply_connected;
	assign charger_fault    = res_s2.charger_fault;

`ifndef SYNTHESIS
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready) else $error("input stalled with free output stage");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2) else $error("advanced request lost");

	a_battery_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.battery_charging && res_s2.battery_error)
		&& !(res_s2.battery_charged && (res_s2.battery_charging || res_s2.battery_error)))
		else $error("battery classes overlap");

	a_charger_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.charger_fault && res_s2.supply_connected))
		else $error("charger classes overlap");
`endif

endmodule
